@@ sv/lctl_pkg.sv @@
// Launch curve torque limit: shared constants, opcodes and pipeline sideband type.
// No dependencies; imported by lctl_div and launch_curve_torque_limit.
`timescale 1ns / 1ps

package lctl_pkg;

    localparam int CURVE_POINTS   = 5;
    localparam int NUM_CURVES     = 4;
    localparam int UPLOADED_CURVE = 3;

    localparam int PT_IW = (CURVE_POINTS > 1) ? $clog2(CURVE_POINTS) : 1;
    localparam int CV_IW = (NUM_CURVES > 1) ? $clog2(NUM_CURVES) : 1;

    // quotient width and bits resolved per divider stage
    localparam int DIV_QW     = 16;
    localparam int DIV_BPS    = 2;
    localparam int DIV_STAGES = DIV_QW / DIV_BPS;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_WR_BP  = 2'd1,
        OP_WR_TQ  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        logic               engaged;
        logic signed [15:0] req;
        logic               direct;
        logic signed [15:0] base;
        logic               neg;
    } t_side;

endpackage

@@ sv/lctl_div.sv @@
// Launch curve torque limit: pipelined unsigned restoring divider, DIV_BPS bits per stage.
// Depends on lctl_pkg; carries a t_side sideband alongside each quotient.
`timescale 1ns / 1ps

module lctl_div import lctl_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [2*DIV_QW-1:0]     i_dividend,
    input  logic [DIV_QW-1:0]       i_divisor,
    input  t_side                   i_side,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [DIV_QW-1:0]       o_quot,
    output t_side                   o_side
);

    // dividend high half must be below the divisor
    function automatic logic [DIV_QW:0] div_step(
        input logic [DIV_QW-1:0] rem,
        input logic              nb,
        input logic [DIV_QW-1:0] dvs
    );
        logic [DIV_QW:0] r;
        logic [DIV_QW:0] d;
        r = {rem, nb};
        d = {1'b0, dvs};
        if (r >= d) begin
            return {1'b1, DIV_QW'(r - d)};
        end
        return {1'b0, r[DIV_QW-1:0]};
    endfunction

    logic              r_vld  [DIV_STAGES];
    logic [DIV_QW-1:0] r_rem  [DIV_STAGES];
    logic [DIV_QW-1:0] r_low  [DIV_STAGES];
    logic [DIV_QW-1:0] r_q    [DIV_STAGES];
    logic [DIV_QW-1:0] r_dvs  [DIV_STAGES];
    t_side             r_side [DIV_STAGES];

    logic [DIV_QW-1:0] n_rem  [DIV_STAGES];
    logic [DIV_QW-1:0] n_low  [DIV_STAGES];
    logic [DIV_QW-1:0] n_q    [DIV_STAGES];
    logic              w_en   [DIV_STAGES];

    always_comb begin
        w_en[DIV_STAGES-1] = !r_vld[DIV_STAGES-1] || i_ready;
        for (int k = DIV_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        logic [DIV_QW-1:0] c_rem;
        logic [DIV_QW-1:0] c_low;
        logic [DIV_QW-1:0] c_q;
        logic [DIV_QW-1:0] c_dvs;
        logic [DIV_QW:0]   c_t;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                c_rem = i_dividend[2*DIV_QW-1:DIV_QW];
                c_low = i_dividend[DIV_QW-1:0];
                c_q   = '0;
                c_dvs = i_divisor;
            end else begin
                c_rem = r_rem[k-1];
                c_low = r_low[k-1];
                c_q   = r_q[k-1];
                c_dvs = r_dvs[k-1];
            end
            for (int b = 0; b < DIV_BPS; b++) begin
                c_t   = div_step(c_rem, c_low[DIV_QW-1], c_dvs);
                c_rem = c_t[DIV_QW-1:0];
                c_q   = {c_q[DIV_QW-2:0], c_t[DIV_QW]};
                c_low = {c_low[DIV_QW-2:0], 1'b0};
            end
            n_rem[k] = c_rem;
            n_low[k] = c_low;
            n_q[k]   = c_q;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_vld[k] <= (k == 0) ? i_valid : r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (w_en[k]) begin
                r_rem[k]  <= n_rem[k];
                r_low[k]  <= n_low[k];
                r_q[k]    <= n_q[k];
                r_dvs[k]  <= (k == 0) ? i_divisor : r_dvs[k-1];
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_quot  = r_q[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];

endmodule

@@ sv/launch_curve_torque_limit.sv @@
// Launch curve torque limit: table writes and pipelined piecewise-linear lookup.
// Depends on lctl_pkg and lctl_div.
//
//  channel  dir  tdata (low bit up)                                  tuser
//  s_axis   in   engaged, curve, point, write val, request, speed    operation
//  m_axis   out  limited_torque (15 bits, zero filled to 16)         limit_applies
//
// One transfer per cycle on either side when not stalled. A lookup passes 14 registers: five
// stages of table read, breakpoint fix-up, compare, segment select and multiply, eight divider
// stages of two quotient bits each, one output register. Writes update the tables on their
// transfer and give no result. Reset clears the pipeline valid bits; tables hold nothing
// until written. Ready is formed combinationally down the whole chain; a stall holds only
// full stages.
`timescale 1ns / 1ps

module launch_curve_torque_limit import lctl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] launch_engaged, [2:1] curve_select, [5:3] point_index, [21:6] write_value,
    // [37:22] requested_torque, [53:38] speed_rpm, [55:54] zero
    input  logic [55:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [14:0] limited_torque, [15] zero
    output logic [15:0] m_axis_tdata,
    // [0] limit_applies
    output logic [0:0]  m_axis_tuser
);

    // input field split
    t_op                w_op;
    logic               w_eng;
    logic [1:0]         w_cur;
    logic [2:0]         w_pidx;
    logic signed [15:0] w_wval;
    logic signed [15:0] w_req;
    logic signed [15:0] w_spd;
    logic               w_acc;

    assign w_op   = t_op'(s_axis_tuser);
    assign w_eng  = s_axis_tdata[0];
    assign w_cur  = s_axis_tdata[2:1];
    assign w_pidx = s_axis_tdata[5:3];
    assign w_wval = s_axis_tdata[21:6];
    assign w_req  = s_axis_tdata[37:22];
    assign w_spd  = s_axis_tdata[53:38];
    assign w_acc  = s_axis_tvalid && s_axis_tready;

    // tables
    logic [15:0]        r_fbp [CURVE_POINTS];
    logic [15:0]        r_ubp [CURVE_POINTS];
    logic signed [15:0] r_tq  [NUM_CURVES][CURVE_POINTS];

    logic               w_pidx_ok;
    logic               w_cur_ok;
    logic               w_upl;
    logic [CV_IW-1:0]   w_lk_cur;
    logic [15:0]        w_abs_spd;

    assign w_pidx_ok = int'(w_pidx) < CURVE_POINTS;
    assign w_cur_ok  = int'(w_cur) < NUM_CURVES;
    assign w_upl     = w_cur_ok && (int'(w_cur) == UPLOADED_CURVE);
    assign w_lk_cur  = w_cur_ok ? CV_IW'(w_cur) : '0;
    assign w_abs_spd = w_spd[15] ? (~w_spd + 16'd1) : w_spd;

    always_ff @(posedge i_clk) begin
        if (w_acc && (w_op == OP_WR_BP) && w_pidx_ok) begin
            if (int'(w_cur) == UPLOADED_CURVE) begin
                r_ubp[PT_IW'(w_pidx)] <= w_wval;
            end else begin
                r_fbp[PT_IW'(w_pidx)] <= w_wval;
            end
        end
        if (w_acc && (w_op == OP_WR_TQ) && w_pidx_ok && w_cur_ok) begin
            r_tq[CV_IW'(w_cur)][PT_IW'(w_pidx)] <= (w_upl && w_wval[15]) ? '0 : w_wval;
        end
    end

    // stage enables
    logic w_en1, w_en2, w_en3, w_en4, w_en5, w_eno;
    logic w_div_rdy, w_div_vld;

    // stage 1: table read
    logic               r_s1_vld;
    logic               r_s1_eng;
    logic signed [15:0] r_s1_req;
    logic [15:0]        r_s1_spd;
    logic               r_s1_upl;
    logic [15:0]        r_s1_bp [CURVE_POINTS];
    logic signed [15:0] r_s1_tq [CURVE_POINTS];

    // stage 2: breakpoints of the uploaded set made monotonic
    logic               r_s2_vld;
    logic               r_s2_eng;
    logic signed [15:0] r_s2_req;
    logic [15:0]        r_s2_spd;
    logic [15:0]        r_s2_bp [CURVE_POINTS];
    logic signed [15:0] r_s2_tq [CURVE_POINTS];
    logic [15:0]        n_s2_bp [CURVE_POINTS];

    // stage 3: compares
    logic               r_s3_vld;
    logic               r_s3_eng;
    logic signed [15:0] r_s3_req;
    logic [15:0]        r_s3_spd;
    logic [15:0]        r_s3_bp [CURVE_POINTS];
    logic signed [15:0] r_s3_tq [CURVE_POINTS];
    logic [CURVE_POINTS-1:0] r_s3_le;
    logic               r_s3_ge;

    // stage 4: segment select
    logic               r_s4_vld;
    t_side              r_s4_side;
    logic [15:0]        r_s4_dmag;
    logic [15:0]        r_s4_ds;
    logic [15:0]        r_s4_span;
    t_side              n_s4_side;
    logic [15:0]        n_s4_dmag;
    logic [15:0]        n_s4_ds;
    logic [15:0]        n_s4_span;

    // stage 5: product
    logic               r_s5_vld;
    t_side              r_s5_side;
    logic [31:0]        r_s5_prod;
    logic [15:0]        r_s5_dvs;

    // divider out and result register
    logic [DIV_QW-1:0]  w_quot;
    t_side              w_dside;
    logic               r_out_vld;
    logic               r_out_app;
    logic [14:0]        r_out_tq;
    logic               n_out_app;
    logic [14:0]        n_out_tq;

    assign w_en5 = !r_s5_vld || w_div_rdy;
    assign w_en4 = !r_s4_vld || w_en5;
    assign w_en3 = !r_s3_vld || w_en4;
    assign w_en2 = !r_s2_vld || w_en3;
    assign w_en1 = !r_s1_vld || w_en2;
    assign w_eno = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_en1) begin
                r_s1_vld <= w_acc && (w_op == OP_LOOKUP);
            end
            if (w_en2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (w_en3) begin
                r_s3_vld <= r_s2_vld;
            end
            if (w_en4) begin
                r_s4_vld <= r_s3_vld;
            end
            if (w_en5) begin
                r_s5_vld <= r_s4_vld;
            end
            if (w_eno) begin
                r_out_vld <= w_div_vld;
            end
        end
    end

    // running non-negative maximum for the uploaded set
    always_comb begin
        logic signed [15:0] prev;
        logic signed [15:0] v;
        prev = '0;
        for (int i = 0; i < CURVE_POINTS; i++) begin
            v = r_s1_bp[i];
            if (v < prev) begin
                v = prev;
            end
            n_s2_bp[i] = r_s1_upl ? v : r_s1_bp[i];
            prev = v;
        end
    end

    always_comb begin
        logic [15:0]        lo_bp;
        logic [15:0]        hi_bp;
        logic signed [15:0] lo_tq;
        logic signed [15:0] hi_tq;
        logic signed [16:0] span;
        logic signed [16:0] dt;
        logic [16:0]        dmag;
        lo_bp = r_s3_bp[0];
        hi_bp = r_s3_bp[1];
        lo_tq = r_s3_tq[0];
        hi_tq = r_s3_tq[1];
        for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
            if (r_s3_le[i]) begin
                lo_bp = r_s3_bp[i-1];
                hi_bp = r_s3_bp[i];
                lo_tq = r_s3_tq[i-1];
                hi_tq = r_s3_tq[i];
            end
        end
        span = $signed({1'b0, hi_bp}) - $signed({1'b0, lo_bp});
        dt   = $signed({hi_tq[15], hi_tq}) - $signed({lo_tq[15], lo_tq});
        dmag = dt[16] ? 17'(-dt) : 17'(dt);

        n_s4_side.engaged = r_s3_eng;
        n_s4_side.req     = r_s3_req;
        n_s4_side.neg     = dt[16];
        n_s4_side.direct  = 1'b1;
        n_s4_side.base    = lo_tq;
        if (r_s3_le[0]) begin
            n_s4_side.base = r_s3_tq[0];
        end else if (r_s3_ge) begin
            n_s4_side.base = r_s3_tq[CURVE_POINTS-1];
        end else if (!span[16] && (span != '0)) begin
            n_s4_side.direct = 1'b0;
        end
        n_s4_dmag = dmag[15:0];
        n_s4_ds   = r_s3_spd - lo_bp;
        n_s4_span = span[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_eng <= w_eng;
            r_s1_req <= w_req;
            r_s1_spd <= w_abs_spd;
            r_s1_upl <= w_upl;
            for (int i = 0; i < CURVE_POINTS; i++) begin
                r_s1_bp[i] <= w_upl ? r_ubp[i] : r_fbp[i];
            end
            r_s1_tq  <= r_tq[w_lk_cur];
        end
        if (w_en2) begin
            r_s2_eng <= r_s1_eng;
            r_s2_req <= r_s1_req;
            r_s2_spd <= r_s1_spd;
            r_s2_bp  <= n_s2_bp;
            r_s2_tq  <= r_s1_tq;
        end
        if (w_en3) begin
            r_s3_eng <= r_s2_eng;
            r_s3_req <= r_s2_req;
            r_s3_spd <= r_s2_spd;
            r_s3_bp  <= r_s2_bp;
            r_s3_tq  <= r_s2_tq;
            for (int i = 0; i < CURVE_POINTS; i++) begin
                r_s3_le[i] <= r_s2_spd <= r_s2_bp[i];
            end
            r_s3_ge  <= r_s2_spd >= r_s2_bp[CURVE_POINTS-1];
        end
        if (w_en4) begin
            r_s4_side <= n_s4_side;
            r_s4_dmag <= n_s4_dmag;
            r_s4_ds   <= n_s4_ds;
            r_s4_span <= n_s4_span;
        end
        if (w_en5) begin
            r_s5_side <= r_s4_side;
            r_s5_prod <= r_s4_dmag * r_s4_ds;
            r_s5_dvs  <= r_s4_span;
        end
        if (w_eno) begin
            r_out_app <= n_out_app;
            r_out_tq  <= n_out_tq;
        end
    end

    lctl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_s5_vld),
        .o_ready    (w_div_rdy),
        .i_dividend (r_s5_prod),
        .i_divisor  (r_s5_dvs),
        .i_side     (r_s5_side),
        .o_valid    (w_div_vld),
        .i_ready    (w_eno),
        .o_quot     (w_quot),
        .o_side     (w_dside)
    );

    // interpolation sum and clamp to [0, request]
    always_comb begin
        logic signed [17:0] base;
        logic signed [17:0] q;
        logic signed [17:0] res;
        logic signed [17:0] req;
        base = 18'(w_dside.base);
        q    = $signed({2'b00, w_quot});
        req  = 18'(w_dside.req);
        if (w_dside.direct) begin
            res = base;
        end else if (w_dside.neg) begin
            res = base - q;
        end else begin
            res = base + q;
        end
        n_out_app = w_dside.engaged;
        n_out_tq  = '0;
        if (w_dside.engaged && !w_dside.req[15] && (w_dside.req != '0)) begin
            if (res > req) begin
                n_out_tq = req[14:0];
            end else if (!res[17]) begin
                n_out_tq = res[14:0];
            end
        end
    end

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tdata    = {1'b0, r_out_tq};
    assign m_axis_tuser[0] = r_out_app;

`ifndef SYNTHESIS
    a_idle_after_reset : assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid straight after reset");

    a_write_no_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_op != OP_LOOKUP)) |=> !r_s1_vld)
        else $error("non-lookup transfer entered the pipeline");

    a_not_engaged_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("torque given without an engaged launch");

    a_div_flow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s5_vld && w_div_rdy) |=> !$stable(u_div.r_vld[0]) || u_div.r_vld[0])
        else $error("divider lost an item");
`endif

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for launch_curve_torque_limit: table writes and curve lookups
// driven on the input stream, results checked in order against a built-in predictor.
// Depends on lctl_pkg and the launch_curve_torque_limit RTL.
`timescale 1ns / 1ps

module tb_top import lctl_pkg::*; ();

    localparam int RANDOM_ITEMS = 690;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        t_op                op;
        logic               engaged;
        logic [1:0]         curve;
        logic [2:0]         point;
        logic signed [15:0] wval;
        logic signed [15:0] req;
        logic signed [15:0] speed;
    } t_cmd;

    typedef struct {
        logic        applies;
        logic [14:0] torque;
    } t_limit;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [0] engaged, [2:1] curve, [5:3] point, [21:6] write value, [37:22] request,
    // [53:38] speed, [55:54] zero
    logic [55:0] s_axis_tdata = '0;
    // [1:0] operation
    logic [1:0]  s_axis_tuser = OP_NONE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [14:0] limited torque, [15] zero
    logic [15:0] m_axis_tdata;
    // [0] limit applies
    logic [0:0]  m_axis_tuser;

    launch_curve_torque_limit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor copy of the tables
    logic        [15:0] fixed_bp    [CURVE_POINTS];
    logic signed [15:0] upload_bp   [CURVE_POINTS];
    logic signed [15:0] curve_pts   [NUM_CURVES][CURVE_POINTS];

    t_cmd   pending_items [$];
    t_limit expected_limits [$];
    t_cmd   on_bus;
    t_limit want;

    int items_total    = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int errors         = 0;
    int n_lookups      = 0;
    int n_limited      = 0;
    int n_writes       = 0;
    int n_ignored      = 0;
    int cyc            = 0;
    int stall_cycles   = 0;
    int hold_left      = 0;
    bit pressure_done  = 0;
    logic quiet;

    assign quiet = (cyc >= 800 && cyc < 1100);

    function automatic t_limit predict_limit(t_cmd c);
        t_limit  r;
        int      bp [CURVE_POINTS];
        int      tq [CURVE_POINTS];
        int      crv, spd, prev, res, i;
        longint  span;
        bit      found;
        r.applies = c.engaged;
        r.torque  = '0;
        if (!c.engaged || c.req <= 0)
            return r;
        crv  = (c.curve >= NUM_CURVES) ? 0 : int'(c.curve);
        prev = 0;
        for (i = 0; i < CURVE_POINTS; i++) begin
            tq[i] = int'(curve_pts[crv][i]);
            if (crv == UPLOADED_CURVE) begin
                bp[i] = (upload_bp[i] < prev) ? prev : int'(upload_bp[i]);
                prev  = bp[i];
            end else begin
                bp[i] = int'(fixed_bp[i]);
            end
        end
        spd = (c.speed < 0) ? -int'(c.speed) : int'(c.speed);
        if (spd <= bp[0]) begin
            res = tq[0];
        end else if (spd >= bp[CURVE_POINTS-1]) begin
            res = tq[CURVE_POINTS-1];
        end else begin
            res   = tq[CURVE_POINTS-1];
            found = 0;
            for (i = 1; i < CURVE_POINTS; i++) begin
                if (!found && spd <= bp[i]) begin
                    found = 1;
                    span  = longint'(bp[i]) - longint'(bp[i-1]);
                    if (span <= 0)
                        res = tq[i-1];
                    else
                        res = int'(longint'(tq[i-1]) + (longint'(tq[i] - tq[i-1]) *
                              longint'(spd - bp[i-1])) / span);
                end
            end
        end
        if (res > c.req)
            res = int'(c.req);
        if (res < 0)
            res = 0;
        r.torque = res[14:0];
        return r;
    endfunction

    task automatic absorb_item(t_cmd c);
        case (c.op)
            OP_WR_BP: begin
                if (c.point < CURVE_POINTS) begin
                    n_writes++;
                    if (c.curve == UPLOADED_CURVE)
                        upload_bp[c.point] = c.wval;
                    else
                        fixed_bp[c.point] = c.wval;
                end else begin
                    n_ignored++;
                end
            end
            OP_WR_TQ: begin
                if (c.point < CURVE_POINTS && c.curve < NUM_CURVES) begin
                    n_writes++;
                    curve_pts[c.curve][c.point] =
                        (c.curve == UPLOADED_CURVE && c.wval < 0) ? 16'sd0 : c.wval;
                end else begin
                    n_ignored++;
                end
            end
            OP_LOOKUP: begin
                n_lookups++;
                if (c.engaged && c.req > 0)
                    n_limited++;
                expected_limits.push_back(predict_limit(c));
            end
            default: n_ignored++;
        endcase
    endtask

    task automatic push_item(t_op op, logic engaged, int curve, int point, int wval,
                             int req, int speed);
        t_cmd c;
        c.op      = op;
        c.engaged = engaged;
        c.curve   = curve[1:0];
        c.point   = point[2:0];
        c.wval    = wval[15:0];
        c.req     = req[15:0];
        c.speed   = speed[15:0];
        pending_items.push_back(c);
        items_total++;
    endtask

    task automatic push_write(t_op op, int curve, int point, int value);
        push_item(op, 1'($urandom_range(1)), curve, point, value,
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
    endtask

    task automatic push_lookup(logic engaged, int curve, int req, int speed);
        push_item(OP_LOOKUP, engaged, curve, $urandom_range(0, 7),
                  $urandom_range(0, 65535), req, speed);
    endtask

    // ascending shared breakpoints, with the odd repeated point
    task automatic load_fixed_bp();
        int v, i;
        v = $urandom_range(0, 2000);
        for (i = 0; i < CURVE_POINTS; i++) begin
            push_write(OP_WR_BP, $urandom_range(0, 2), i, v);
            v += ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 12000);
            if (v > 65535)
                v = 65535;
        end
    endtask

    task automatic load_upload_bp();
        int v, i;
        bit sorted;
        sorted = ($urandom_range(9) < 7);
        v = $urandom_range(0, 3000) - 1000;
        for (i = 0; i < CURVE_POINTS; i++) begin
            if (sorted) begin
                push_write(OP_WR_BP, UPLOADED_CURVE, i, v);
                v += ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 9000);
                if (v > 32767)
                    v = 32767;
            end else begin
                push_write(OP_WR_BP, UPLOADED_CURVE, i, $urandom_range(0, 16000) - 4000);
            end
        end
    endtask

    task automatic load_curve(int crv);
        int i;
        for (i = 0; i < CURVE_POINTS; i++) begin
            if ($urandom_range(4) == 0)
                push_write(OP_WR_TQ, crv, i, $urandom_range(0, 65535) - 32768);
            else
                push_write(OP_WR_TQ, crv, i, $urandom_range(0, 1600) - 100);
        end
    endtask

    task automatic fill_stimulus();
        int count, pick, mag, spd, req;
        // initial table image: every entry written before any lookup
        push_write(OP_WR_BP, 0, 0, 0);
        push_write(OP_WR_BP, 1, 1, 1000);
        push_write(OP_WR_BP, 2, 2, 2000);
        push_write(OP_WR_BP, 0, 3, 4000);
        push_write(OP_WR_BP, 1, 4, 8000);
        push_write(OP_WR_BP, 3, 0, -50);
        push_write(OP_WR_BP, 3, 1, 500);
        push_write(OP_WR_BP, 3, 2, 300);
        push_write(OP_WR_BP, 3, 3, 3000);
        push_write(OP_WR_BP, 3, 4, 6000);
        push_write(OP_WR_TQ, 0, 0, 100);
        push_write(OP_WR_TQ, 0, 1, 200);
        push_write(OP_WR_TQ, 0, 2, 400);
        push_write(OP_WR_TQ, 0, 3, 400);
        push_write(OP_WR_TQ, 0, 4, -50);
        push_write(OP_WR_TQ, 1, 0, 0);
        push_write(OP_WR_TQ, 1, 1, 1000);
        push_write(OP_WR_TQ, 1, 2, 32767);
        push_write(OP_WR_TQ, 1, 3, 500);
        push_write(OP_WR_TQ, 1, 4, 300);
        push_write(OP_WR_TQ, 2, 0, -32768);
        push_write(OP_WR_TQ, 2, 1, 0);
        push_write(OP_WR_TQ, 2, 2, 250);
        push_write(OP_WR_TQ, 2, 3, 600);
        push_write(OP_WR_TQ, 2, 4, 900);
        push_write(OP_WR_TQ, 3, 0, -20);
        push_write(OP_WR_TQ, 3, 1, 300);
        push_write(OP_WR_TQ, 3, 2, 600);
        push_write(OP_WR_TQ, 3, 3, 900);
        push_write(OP_WR_TQ, 3, 4, 1200);

        // directed lookups
        push_lookup(1'b0, 1, 500, 1500);
        push_lookup(1'b0, 2, -5, 100);
        push_lookup(1'b1, 1, 0, 1500);
        push_lookup(1'b1, 1, -32768, 1500);
        push_lookup(1'b1, 0, 32767, -32768);
        push_lookup(1'b1, 1, 32767, 32767);
        push_lookup(1'b1, 1, 32767, 0);
        push_lookup(1'b1, 1, 32767, 2000);
        push_lookup(1'b1, 1, 32767, 1500);
        push_lookup(1'b1, 1, 100, 1500);
        push_lookup(1'b1, 2, 32767, -300);
        push_lookup(1'b1, 2, 32767, -7000);
        push_lookup(1'b1, 3, 32767, 250);
        push_lookup(1'b1, 3, 32767, 2000);
        push_lookup(1'b1, 3, 32767, -32768);
        // negative uploaded torque is floored on write
        push_write(OP_WR_TQ, 3, 0, -1);
        push_lookup(1'b1, 3, 32767, 0);
        // out of range points and the spare opcode change nothing
        push_write(OP_WR_BP, 0, 5, 123);
        push_write(OP_WR_TQ, 1, 7, -1);
        push_write(OP_WR_BP, 3, 6, 77);
        push_item(OP_NONE, 1'b1, 3, 7, -1, -1, -1);
        push_lookup(1'b1, 1, 32767, 1500);
        // top breakpoint above the speed range, read unsigned
        push_write(OP_WR_BP, 2, 4, 65535);
        push_lookup(1'b1, 1, 32767, -32768);
        push_write(OP_WR_BP, 0, 4, 8000);

        count = 0;
        while (count < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                case ($urandom_range(2))
                    0: load_fixed_bp();
                    1: load_upload_bp();
                    default: load_curve($urandom_range(0, NUM_CURVES - 1));
                endcase
                count += CURVE_POINTS;
            end else if (pick < 8) begin
                push_write(t_op'($urandom_range(1, 2)), $urandom_range(0, 3),
                           $urandom_range(0, CURVE_POINTS - 1), $urandom_range(0, 65535));
                count++;
            end else if (pick < 10) begin
                if ($urandom_range(1))
                    push_item(OP_NONE, 1'($urandom_range(1)), $urandom_range(0, 3),
                              $urandom_range(0, 7), $urandom_range(0, 65535),
                              $urandom_range(0, 65535), $urandom_range(0, 65535));
                else
                    push_write(t_op'($urandom_range(1, 2)), $urandom_range(0, 3),
                               $urandom_range(CURVE_POINTS, 7), $urandom_range(0, 65535));
                count++;
            end else begin
                if ($urandom_range(9) < 7) begin
                    mag = $urandom_range(0, 25000);
                    spd = $urandom_range(1) ? -mag : mag;
                end else begin
                    spd = $urandom_range(0, 65535);
                end
                pick = $urandom_range(99);
                if (pick < 45)
                    req = $urandom_range(1, 2000);
                else if (pick < 80)
                    req = $urandom_range(1, 32767);
                else
                    req = $urandom_range(0, 65535);
                push_lookup($urandom_range(9) != 0, $urandom_range(0, 3), req, spd);
                count++;
            end
        end
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                absorb_item(on_bus);
                items_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= 21)) begin
                    on_bus = pending_items.pop_front();
                    s_axis_tdata  <= {2'b00, on_bus.speed, on_bus.req, on_bus.wval,
                                      on_bus.point, on_bus.curve, on_bus.engaged};
                    s_axis_tuser  <= on_bus.op;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_limits.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, got applies %0d torque %0d",
                             $time, m_axis_tuser[0], m_axis_tdata[14:0]);
                end else begin
                    want = expected_limits.pop_front();
                    if (m_axis_tuser[0] !== want.applies) begin
                        errors++;
                        $display("%0t: limit_applies mismatch: expected %0d, got %0d",
                                 $time, want.applies, m_axis_tuser[0]);
                    end
                    if (m_axis_tdata[14:0] !== want.torque) begin
                        errors++;
                        $display("%0t: limited_torque mismatch: expected %0d, got %0d",
                                 $time, want.torque, m_axis_tdata[14:0]);
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!pressure_done && results_seen >= 150) begin
                pressure_done = 1;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= quiet || ($urandom_range(99) >= 21);
            end
        end
    end

    // watchdog on transfer activity
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        fill_stimulus();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (items_accepted != items_total || expected_limits.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_limits.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, expected_limits.size());
        end
        $display("Run covered %0d lookups (%0d through the curves), %0d table writes,",
                 n_lookups, n_limited, n_writes);
        $display("%0d ignored transfers and %0d checked results, with one long output stall",
                 n_ignored, results_seen);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
